/* design/wrst_pkg.sv */
// Package for the weighted random server table: payload structs, codes.
// No dependencies.
`default_nettype none
package wrst_pkg;
   localparam int ID_W  = 64;
   localparam int WT_W  = 32;
   localparam int SUM_W = 39;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_SELECT = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MISSING  = 3'd1,
      ST_BAD_WT   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4,
      ST_RANGE    = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]       func;
      logic [ID_W-1:0]  server_id;
      logic [WT_W-1:0]  weight;
      logic [SUM_W-1:0] draw;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [ID_W-1:0]  chosen_id;
      logic [6:0]       chosen_slot;
      logic [7:0]       entry_count;
      logic [SUM_W-1:0] total_weight;
   } rsp_type;

   typedef struct packed {
      func_type         func;
      logic [ID_W-1:0]  server_id;
      logic [WT_W-1:0]  weight;
      logic             weight_bad;
      logic [SUM_W-1:0] draw;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_MOVE,
      BK_FIX,
      BK_DONE
   } back_state_type;
endpackage
`default_nettype wire

/* design/wrst_front.sv */
// Front end: accepts requests, resolves default weight, queues commands.
// Depends on wrst_pkg.
`default_nettype none
module wrst_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire wrst_pkg::req_type req_data,
   input  wire logic [31:0]      default_weight,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output wrst_pkg::cmd_type     cmd_data
);
   wrst_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   wrst_pkg::cmd_type c;
   logic push, pop;

   always_comb begin
      c.func       = wrst_pkg::func_type'(req_data.func);
      c.server_id  = req_data.server_id;
      c.draw       = req_data.draw;
      c.weight     = (req_data.weight == '0) ? default_weight : req_data.weight;
      c.weight_bad = (req_data.weight == '0) && (default_weight == '0);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rp_ff];
   assign push = req_valid && req_ready;
   assign pop  = cmd_valid && cmd_ready;
   assign wp_in = wp_ff ^ push;
   assign rp_in = rp_ff ^ pop;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= c;
      if (reset) begin
         cnt_ff <= '0; wp_ff <= 1'b0; rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; wp_ff <= wp_in; rp_ff <= rp_in;
      end
   end
endmodule
`default_nettype wire

/* design/wrst_back.sv */
// Back end: table memories and the scan, move and fix-up sequencer.
// Depends on wrst_pkg.
`default_nettype none
module wrst_back #(
   parameter int MAX_TARGETS = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire wrst_pkg::cmd_type cmd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wrst_pkg::rsp_type      rsp_data
);
   localparam int AW = $clog2(MAX_TARGETS);
   localparam int CW = $clog2(MAX_TARGETS + 1);
   localparam int SW = wrst_pkg::SUM_W;

   logic [63:0]   id_mem [MAX_TARGETS];
   logic [31:0]   wt_mem [MAX_TARGETS];
   logic [SW-1:0] rs_mem [MAX_TARGETS];

   wrst_pkg::back_state_type st_ff, st_in;
   wrst_pkg::cmd_type cmd_ff, cmd_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [SW-1:0] tot_ff, tot_in, below_ff, below_in;
   logic          rd_ok_ff, rd_ok_in;
   logic [63:0]   rid_ff;
   logic [31:0]   rwt_ff;
   logic [SW-1:0] rrs_ff;
   logic [AW-1:0] ra;
   logic          re;
   logic [AW-1:0] wa;
   logic [63:0]   wid;
   logic [31:0]   wwt;
   logic [SW-1:0] wrs;
   logic          wid_en, wwt_en, wrs_en;
   logic          ov_ff, ov_in;
   logic [2:0]    status_ff, status_in;
   logic [63:0]   cid_ff, cid_in;
   logic [6:0]    cslot_ff, cslot_in;
   wrst_pkg::rsp_type out_ff, out_in;
   logic [SW:0]   sum_w;
   logic [SW-1:0] nb;

   always_ff @(posedge clock) begin
      if (re) begin
         rid_ff <= id_mem[ra];
         rwt_ff <= wt_mem[ra];
         rrs_ff <= rs_mem[ra];
      end
      if (wid_en) id_mem[wa] <= wid;
      if (wwt_en) wt_mem[wa] <= wwt;
      if (wrs_en) rs_mem[wa] <= wrs;
   end

   assign sum_w = {1'b0, tot_ff} + {{(SW - 31){1'b0}}, cmd_ff.weight};
   assign nb = below_ff + {{(SW - 32){1'b0}}, rwt_ff};
   assign cmd_ready = (st_ff == wrst_pkg::BK_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;

   always_comb begin
      st_in = st_ff; cmd_in = cmd_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      slot_in = slot_ff; tot_in = tot_ff; below_in = below_ff; rd_ok_in = 1'b0;
      ov_in = ov_ff; status_in = status_ff; cid_in = cid_ff; cslot_in = cslot_ff;
      out_in = out_ff;
      re = 1'b0; ra = idx_ff[AW-1:0];
      wa = slot_ff; wid = rid_ff; wwt = rwt_ff; wrs = nb;
      wid_en = 1'b0; wwt_en = 1'b0; wrs_en = 1'b0;
      if (rsp_valid && rsp_ready) ov_in = 1'b0;
      case (st_ff)
         wrst_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_data; idx_in = '0; st_in = wrst_pkg::BK_SCAN;
               status_in = wrst_pkg::ST_OK; cid_in = '0; cslot_in = '0;
            end
         end
         wrst_pkg::BK_SCAN: begin
            if (rd_ok_ff) begin
               if (cmd_ff.func == wrst_pkg::FUNC_SELECT) begin
                  if (rrs_ff > cmd_ff.draw) begin
                     cid_in = rid_ff; cslot_in = 7'(idx_ff - 1'b1);
                     st_in = wrst_pkg::BK_DONE;
                  end
               end else if (rid_ff == cmd_ff.server_id) begin
                  slot_in = AW'(idx_ff - 1'b1);
                  if (cmd_ff.func == wrst_pkg::FUNC_ADD) begin
                     status_in = wrst_pkg::ST_MISSING; st_in = wrst_pkg::BK_DONE;
                  end else begin
                     tot_in = tot_ff - {{(SW - 32){1'b0}}, rwt_ff};
                     below_in = (idx_ff == CW'(1)) ? '0 : rrs_ff - {{(SW - 32){1'b0}}, rwt_ff};
                     re = 1'b1; ra = AW'(cnt_ff - 1'b1);
                     st_in = wrst_pkg::BK_MOVE;
                  end
               end
            end
            if (st_in == wrst_pkg::BK_SCAN) begin
               if (idx_ff < cnt_ff) begin
                  re = 1'b1; rd_ok_in = 1'b1; idx_in = idx_ff + 1'b1;
               end else if (!rd_ok_ff) begin
                  st_in = wrst_pkg::BK_DONE;
                  case (cmd_ff.func)
                     wrst_pkg::FUNC_ADD: begin
                        if (cmd_ff.weight_bad) status_in = wrst_pkg::ST_BAD_WT;
                        else if (cnt_ff >= CW'(MAX_TARGETS)) status_in = wrst_pkg::ST_FULL;
                        else if (sum_w[SW]) status_in = wrst_pkg::ST_BAD_WT;
                        else begin
                           wa = AW'(cnt_ff); wid = cmd_ff.server_id;
                           wwt = cmd_ff.weight; wrs = sum_w[SW-1:0];
                           wid_en = 1'b1; wwt_en = 1'b1; wrs_en = 1'b1;
                           cnt_in = cnt_ff + 1'b1; tot_in = sum_w[SW-1:0];
                        end
                     end
                     wrst_pkg::FUNC_REMOVE: status_in = wrst_pkg::ST_MISSING;
                     wrst_pkg::FUNC_SELECT: begin
                        if (cnt_ff == '0) status_in = wrst_pkg::ST_EMPTY;
                        else status_in = wrst_pkg::ST_RANGE;
                     end
                     default: status_in = wrst_pkg::ST_OK;
                  endcase
               end
               if (cmd_ff.func == wrst_pkg::FUNC_ADD && cmd_ff.weight_bad) begin
                  status_in = wrst_pkg::ST_BAD_WT; st_in = wrst_pkg::BK_DONE; re = 1'b0;
               end
               if (cmd_ff.func == wrst_pkg::FUNC_SELECT && cnt_ff != '0
                   && cmd_ff.draw >= tot_ff) begin
                  status_in = wrst_pkg::ST_RANGE; st_in = wrst_pkg::BK_DONE; re = 1'b0;
               end
               if (cmd_ff.func == wrst_pkg::FUNC_NOP) begin
                  st_in = wrst_pkg::BK_DONE; re = 1'b0;
               end
            end
         end
         wrst_pkg::BK_MOVE: begin
            wa = slot_ff; wid = rid_ff; wwt = rwt_ff;
            wid_en = 1'b1; wwt_en = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            idx_in = {1'b0, slot_ff};
            if ({1'b0, slot_ff} >= cnt_in) st_in = wrst_pkg::BK_DONE;
            else begin
               re = 1'b1; ra = slot_ff; st_in = wrst_pkg::BK_FIX;
            end
         end
         wrst_pkg::BK_FIX: begin
            if (rd_ok_ff) begin
               wa = AW'(idx_ff - 1'b1); wrs = nb; wrs_en = 1'b1; below_in = nb;
            end
            if (idx_ff < cnt_ff && !(rd_ok_ff == 1'b0 && idx_ff != {1'b0, slot_ff})) begin
               re = 1'b1; ra = idx_ff[AW-1:0];
               rd_ok_in = 1'b1; idx_in = idx_ff + 1'b1;
            end else if (idx_ff >= cnt_ff) begin
               st_in = wrst_pkg::BK_DONE;
            end
         end
         wrst_pkg::BK_DONE: begin
            if (!ov_ff || (rsp_valid && rsp_ready)) begin
               ov_in = 1'b1; st_in = wrst_pkg::BK_IDLE;
               out_in.status = status_ff;
               out_in.chosen_id = cid_ff;
               out_in.chosen_slot = cslot_ff;
               out_in.entry_count = 8'(cnt_ff);
               out_in.total_weight = tot_ff;
            end
         end
         default: st_in = wrst_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; idx_ff <= idx_in; slot_ff <= slot_in; below_ff <= below_in;
      status_ff <= status_in; cid_ff <= cid_in; cslot_ff <= cslot_in;
      out_ff <= out_in;
      if (reset) begin
         st_ff <= wrst_pkg::BK_IDLE; cnt_ff <= '0; tot_ff <= '0;
         ov_ff <= 1'b0; rd_ok_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; tot_ff <= tot_in;
         ov_ff <= ov_in; rd_ok_ff <= rd_ok_in;
      end
   end
endmodule
`default_nettype wire

/* design/weighted_random_server_table.sv */
// Weighted random server table, top level.
// Depends on wrst_pkg, wrst_front and wrst_back.
//
// Requests (add, remove, select, nop) arrive on req_valid/req_ready and each
// yields one response on rsp_valid/rsp_ready. The front end resolves the
// default weight and holds up to two requests in a small queue; the back
// end walks the table memory one entry per cycle, and a remove then walks
// again from the removed slot to the end to rewrite the running sums. The
// back end takes one request at a time, bounded by that memory port walk.
// A response waits in the output register while the receiver stalls; the
// back end finishes the next request and holds its result until the
// waiting response is taken, and the queue fills.
// csr_write_enable loads default_weight (reset value 1) into a register.
// Synchronous reset empties the table, clears count and total and drops
// queued requests; no clearing pass over the memories is needed.
`default_nettype none
module weighted_random_server_table #(
   parameter int MAX_TARGETS = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire wrst_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wrst_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [31:0]       csr_write_data
);
   logic [31:0] dw_ff;
   logic cmd_valid, cmd_ready;
   wrst_pkg::cmd_type cmd_data;

   always_ff @(posedge clock) begin
      if (reset) dw_ff <= 32'd1;
      else if (csr_write_enable) dw_ff <= csr_write_data;
   end

   wrst_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .default_weight(dw_ff), .cmd_valid, .cmd_ready, .cmd_data
   );

   wrst_back #(.MAX_TARGETS(MAX_TARGETS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
`default_nettype wire
